// File: rtl/ddpi_pkg.sv
// ----------------------------------------------------------------------------
// ddpi_pkg
// Shared types, constants and arithmetic helpers for the profiled PI step unit.
// ----------------------------------------------------------------------------
package ddpi_pkg;

    localparam int TRAVEL_W   = 24;
    localparam int SPEED_W    = 16;
    localparam int DRIVE_W    = 9;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int QUOT_W     = 42;
    localparam int WIDE_W     = 50;

    localparam logic [CFG_IDX_W-1:0] REG_MODE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CRUISE    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_PROP = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_INT  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_X    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_DRIVE_MIN = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_DRIVE_MAX = 3'd7;

    localparam int STRAIGHT_TOL = 80;
    localparam int TURN_TOL     = 8;

    typedef enum logic [3:0] {
        S_IDLE, S_PREP1, S_PREP2, S_BRANCH, S_MUL_NUM, S_DIV_LOAD, S_DIV,
        S_SET_ERR, S_INTEG, S_MR1, S_MR2, S_ML1, S_ML2, S_MC, S_CORR, S_FIN
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE, OP_LOAD, OP_PREP1, OP_PREP2, OP_MUL_NUM, OP_DIV_LOAD,
        OP_DIV_STEP, OP_SET_ERR, OP_INTEG, OP_MR1, OP_MR2, OP_ML1, OP_ML2,
        OP_MC, OP_CORR, OP_FIN
    } op_t;

    typedef enum logic [1:0] {
        PK_ZERO, PK_DIV, PK_CRUISE
    } prof_kind_t;

    typedef struct packed {
        logic arrived;
        logic need_div;
        logic div_last;
    } dp_status_t;

    // Saturate a wide signed value to the signed 32-bit range.
    function automatic logic signed [31:0] sat32(input logic signed [WIDE_W-1:0] v);
        if (v > 50'sd2147483647) begin
            return 32'sh7FFF_FFFF;
        end else if (v < -50'sd2147483648) begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    // Arithmetic right shift that rounds toward zero, as a signed divide would.
    function automatic logic signed [WIDE_W-1:0] trunc_shr(input logic signed [WIDE_W-1:0] v,
                                                          input int sh);
        logic signed [WIDE_W-1:0] bias;
        bias = (v < 0) ? ((50'sd1 <<< sh) - 50'sd1) : 50'sd0;
        return (v + bias) >>> sh;
    endfunction

    // Clamp to the drive band of one wheel; the low bound is tested first, so if inverted it wins below it.
    function automatic logic signed [DRIVE_W-1:0] band(input logic signed [WIDE_W-1:0] v,
                                                      input logic neg,
                                                      input logic [7:0] mn,
                                                      input logic [7:0] mx);
        logic signed [WIDE_W-1:0] lo;
        logic signed [WIDE_W-1:0] hi;
        logic signed [WIDE_W-1:0] r;
        lo = neg ? -$signed({42'd0, mx}) : $signed({42'd0, mn});
        hi = neg ? -$signed({42'd0, mn}) : $signed({42'd0, mx});
        if (v < lo) begin
            r = lo;
        end else if (v > hi) begin
            r = hi;
        end else begin
            r = v;
        end
        return r[DRIVE_W-1:0];
    endfunction

endpackage

// File: rtl/diff_drive_profiled_pi_step_unit.sv
// ----------------------------------------------------------------------------
// diff_drive_profiled_pi_step_unit
// Trapezoidal-profile PI velocity step for a two-wheel differential drive.
// ----------------------------------------------------------------------------
// One transfer on the s_ channel is one control tick; exactly one result
// transfer follows on the m_ channel. A tick that lands inside the arrival
// tolerance skips from preparation to the result, a tick on the cruise plateau
// or with a zero target runs the PI products, and a tick on either ramp also
// runs the divider first, because the ramp set point is divided by the target
// distance in a radix-2 divider that retires one of 42 quotient bits per cycle.
// All products go through a single shared 17 x 33 multiplier, one per cycle.
// The unit works on one tick at a time; the result sits in an output register,
// so the next tick can be accepted while the previous result still waits for
// m_ready. Configuration writes are always accepted, clear both integrators,
// and are meant to arrive only while the unit is idle.
// ----------------------------------------------------------------------------
module diff_drive_profiled_pi_step_unit
    import ddpi_pkg::*;
(
    input  logic                        aclk,
    input  logic                        aresetn,

    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic signed [TRAVEL_W-1:0]  s_travel_right,
    input  logic signed [TRAVEL_W-1:0]  s_travel_left,
    input  logic signed [TRAVEL_W-1:0]  s_travel_centre,
    input  logic signed [SPEED_W-1:0]   s_speed_right,
    input  logic signed [SPEED_W-1:0]   s_speed_left,

    output logic                        m_valid,
    input  logic                        m_ready,
    output logic signed [DRIVE_W-1:0]   m_drive_right,
    output logic signed [DRIVE_W-1:0]   m_drive_left,
    output logic                        m_arrived,

    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_DATA_W-1:0]       cfg_data
);

    op_t        op;
    dp_status_t status;

    // The register file never stalls a configuration transfer.
    assign cfg_ready = 1'b1;

    ddpi_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .op      (op)
    );

    ddpi_dpath u_dpath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .op            (op),
        .status        (status),
        .cfg_we        (cfg_valid && cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .travel_right  (s_travel_right),
        .travel_left   (s_travel_left),
        .travel_centre (s_travel_centre),
        .speed_right   (s_speed_right),
        .speed_left    (s_speed_left),
        .drive_right   (m_drive_right),
        .drive_left    (m_drive_left),
        .arrived       (m_arrived)
    );

    // An arrived result always carries zero drive on both wheels.
    a_arrived_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_arrived |-> (m_drive_right == 9'sd0) && (m_drive_left == 9'sd0))
        else $error("arrived result with nonzero drive");

    // The band limits keep every drive inside +/-255.
    a_drive_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_drive_right != -9'sd256) && (m_drive_left != -9'sd256))
        else $error("drive outside the PWM range");

    // After a tick is accepted, s_ready is low in the cycle that follows.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted twice in a row");

endmodule

// File: rtl/ddpi_ctrl.sv
// ----------------------------------------------------------------------------
// ddpi_ctrl
// Sequencer that steps the datapath through one control tick.
// ----------------------------------------------------------------------------
module ddpi_ctrl
    import ddpi_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    output logic       m_valid,
    input  logic       m_ready,
    input  dp_status_t status,
    output op_t        op
);

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        op           = OP_NONE;
        s_ready      = 1'b0;
        m_valid_next = (m_valid_reg && m_ready) ? 1'b0 : m_valid_reg;
        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    op         = OP_LOAD;
                    state_next = S_PREP1;
                end
            end
            S_PREP1: begin
                op         = OP_PREP1;
                state_next = S_PREP2;
            end
            S_PREP2: begin
                op         = OP_PREP2;
                state_next = S_BRANCH;
            end
            S_BRANCH: begin
                if (status.arrived) begin
                    state_next = S_FIN;
                end else if (status.need_div) begin
                    state_next = S_MUL_NUM;
                end else begin
                    state_next = S_SET_ERR;
                end
            end
            S_MUL_NUM: begin
                op         = OP_MUL_NUM;
                state_next = S_DIV_LOAD;
            end
            S_DIV_LOAD: begin
                op         = OP_DIV_LOAD;
                state_next = S_DIV;
            end
            S_DIV: begin
                op = OP_DIV_STEP;
                if (status.div_last) begin
                    state_next = S_SET_ERR;
                end
            end
            S_SET_ERR: begin
                op         = OP_SET_ERR;
                state_next = S_INTEG;
            end
            S_INTEG: begin
                op         = OP_INTEG;
                state_next = S_MR1;
            end
            S_MR1: begin
                op         = OP_MR1;
                state_next = S_MR2;
            end
            S_MR2: begin
                op         = OP_MR2;
                state_next = S_ML1;
            end
            S_ML1: begin
                op         = OP_ML1;
                state_next = S_ML2;
            end
            S_ML2: begin
                op         = OP_ML2;
                state_next = S_MC;
            end
            S_MC: begin
                op         = OP_MC;
                state_next = S_CORR;
            end
            S_CORR: begin
                op         = OP_CORR;
                state_next = S_FIN;
            end
            S_FIN: begin
                if (!m_valid_reg || m_ready) begin
                    op           = OP_FIN;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign m_valid = m_valid_reg;

endmodule

// File: rtl/ddpi_dpath.sv
// ----------------------------------------------------------------------------
// ddpi_dpath
// Registers, shared multiplier, radix-2 divider and clamps of the PI step.
// ----------------------------------------------------------------------------
module ddpi_dpath
    import ddpi_pkg::*;
(
    input  logic                        aclk,
    input  logic                        aresetn,
    input  op_t                         op,
    output dp_status_t                  status,
    input  logic                        cfg_we,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_DATA_W-1:0]       cfg_data,
    input  logic signed [TRAVEL_W-1:0]  travel_right,
    input  logic signed [TRAVEL_W-1:0]  travel_left,
    input  logic signed [TRAVEL_W-1:0]  travel_centre,
    input  logic signed [SPEED_W-1:0]   speed_right,
    input  logic signed [SPEED_W-1:0]   speed_left,
    output logic signed [DRIVE_W-1:0]   drive_right,
    output logic signed [DRIVE_W-1:0]   drive_left,
    output logic                        arrived
);

    // Configuration.
    logic                       mode_reg;
    logic signed [23:0]         target_reg;
    logic [14:0]                cruise_reg;
    logic [15:0]                gp_reg, gi_reg, gx_reg;
    logic [7:0]                 dmin_reg, dmax_reg;
    logic signed [31:0]         integ_r_reg, integ_l_reg;

    // Latched tick inputs.
    logic signed [TRAVEL_W-1:0] tr_reg, tl_reg, tc_reg;
    logic signed [SPEED_W-1:0]  sr_reg, sl_reg;

    // Preparation results.
    logic signed [25:0]         dx_reg, ec_reg, xs_reg, cd_reg;
    logic [23:0]                dmag_reg;
    logic                       dirneg_reg;
    logic                       arrived_reg;
    prof_kind_t                 kind_reg;
    logic [24:0]                m_reg;
    logic                       nsgn_reg, sh2_reg;

    // Divider, multiplier and accumulation.
    logic [QUOT_W-1:0]          dvd_reg;
    logic [23:0]                rem_reg;
    logic [5:0]                 cnt_reg;
    logic signed [WIDE_W-1:0]   prod_reg, acc_reg;
    logic signed [31:0]         err_r_reg, err_l_reg, corr_reg;
    logic signed [DRIVE_W-1:0]  dr_reg, dl_reg;
    logic signed [DRIVE_W-1:0]  out_r_reg, out_l_reg;
    logic                       out_arr_reg;

    // Combinational helpers.
    logic signed [25:0] tr26, tl26, tc26, t26, dx26, abs_tc;
    logic signed [26:0] dxt27;
    logic signed [27:0] d28, x28, dmx28, dx28, adx28, tdiff28, ec28;
    logic               arr_now;
    logic [15:0]        mul_a;
    logic signed [32:0] mul_b;
    logic signed [WIDE_W-1:0] mul_p;
    logic [24:0]        rem_sh;
    logic               div_ge;
    logic signed [43:0] quot44, prof44, set44, setl44;
    logic               dirneg_l;
    logic signed [WIDE_W-1:0] fin_r, fin_l;

    assign tr26   = 26'(tr_reg);
    assign tl26   = 26'(tl_reg);
    assign tc26   = 26'(tc_reg);
    assign t26    = 26'(target_reg);
    assign dx26   = tr26 - tl26;
    assign abs_tc = (tc26 < 0) ? -tc26 : tc26;
    assign dxt27  = 27'(dx26) - 27'(t26);

    assign d28     = $signed({4'd0, dmag_reg});
    assign x28     = 28'(xs_reg);
    assign dmx28   = d28 - x28;
    assign dx28    = 28'(dx_reg);
    assign adx28   = (dx28 < 0) ? -dx28 : dx28;
    assign tdiff28 = adx28 - d28;
    assign ec28    = 28'(ec_reg);
    assign arr_now = mode_reg ? ((tdiff28 <= 28'sd8) && (tdiff28 >= -28'sd8))
                              : ((ec28 <= 28'sd80) && (ec28 >= -28'sd80));

    always_comb begin
        mul_a = gp_reg;
        mul_b = 33'(err_r_reg);
        unique case (op)
            OP_MUL_NUM: begin
                mul_a = {1'b0, cruise_reg};
                mul_b = $signed({8'd0, m_reg});
            end
            OP_MR2: begin
                mul_a = gi_reg;
                mul_b = 33'(integ_r_reg);
            end
            OP_ML1: begin
                mul_a = gp_reg;
                mul_b = 33'(err_l_reg);
            end
            OP_ML2: begin
                mul_a = gi_reg;
                mul_b = 33'(integ_l_reg);
            end
            OP_MC: begin
                mul_a = gx_reg;
                mul_b = 33'(cd_reg);
            end
            default: begin
                mul_a = gp_reg;
                mul_b = 33'(err_r_reg);
            end
        endcase
    end

    assign mul_p  = $signed({1'b0, mul_a}) * mul_b;
    assign rem_sh = {rem_reg, dvd_reg[QUOT_W-1]};
    assign div_ge = rem_sh >= {1'b0, dmag_reg};

    always_comb begin
        quot44 = $signed({2'b00, dvd_reg});
        unique case (kind_reg)
            PK_DIV:    prof44 = nsgn_reg ? -quot44 : quot44;
            PK_CRUISE: prof44 = $signed({29'd0, cruise_reg});
            default:   prof44 = 44'sd0;
        endcase
        set44  = dirneg_reg ? -prof44 : prof44;
        setl44 = mode_reg ? -set44 : set44;
    end

    assign dirneg_l = mode_reg ? ~dirneg_reg : dirneg_reg;
    assign fin_r = mode_reg ? (50'(dr_reg) + 50'(corr_reg)) : (50'(dr_reg) - 50'(corr_reg));
    assign fin_l = mode_reg ? (50'(dl_reg) - 50'(corr_reg)) : (50'(dl_reg) + 50'(corr_reg));

    // Configuration and control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= 1'b0;
            target_reg  <= '0;
            cruise_reg  <= '0;
            gp_reg      <= '0;
            gi_reg      <= '0;
            gx_reg      <= '0;
            dmin_reg    <= '0;
            dmax_reg    <= 8'd255;
            integ_r_reg <= '0;
            integ_l_reg <= '0;
            cnt_reg     <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_MODE:      mode_reg   <= cfg_data[0];
                REG_TARGET:    target_reg <= $signed(cfg_data[23:0]);
                REG_CRUISE:    cruise_reg <= cfg_data[14:0];
                REG_GAIN_PROP: gp_reg     <= cfg_data[15:0];
                REG_GAIN_INT:  gi_reg     <= cfg_data[15:0];
                REG_GAIN_X:    gx_reg     <= cfg_data[15:0];
                REG_DRIVE_MIN: dmin_reg   <= cfg_data[7:0];
                REG_DRIVE_MAX: dmax_reg   <= cfg_data[7:0];
                default:       mode_reg   <= mode_reg;
            endcase
            integ_r_reg <= '0;
            integ_l_reg <= '0;
        end else begin
            if (op == OP_INTEG) begin
                integ_r_reg <= sat32(50'(integ_r_reg) + 50'(err_r_reg));
                integ_l_reg <= sat32(50'(integ_l_reg) + 50'(err_l_reg));
            end
            if (op == OP_DIV_LOAD) begin
                cnt_reg <= 6'(QUOT_W - 1);
            end else if (op == OP_DIV_STEP) begin
                cnt_reg <= cnt_reg - 6'd1;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        unique case (op)
            OP_LOAD: begin
                tr_reg <= travel_right;
                tl_reg <= travel_left;
                tc_reg <= travel_centre;
                sr_reg <= speed_right;
                sl_reg <= speed_left;
            end
            OP_PREP1: begin
                dx_reg     <= dx26;
                ec_reg     <= tc26 - t26;
                xs_reg     <= mode_reg ? dx26 : abs_tc;
                cd_reg     <= mode_reg ? (tr26 + tl26) : dx26;
                dmag_reg   <= 24'((t26 < 0) ? -t26 : t26);
                dirneg_reg <= mode_reg ? (dxt27 >= 0) : ((tc26 - t26) >= 0);
            end
            OP_PREP2: begin
                arrived_reg <= arr_now;
                nsgn_reg    <= 1'b0;
                sh2_reg     <= 1'b0;
                m_reg       <= '0;
                if (dmag_reg == 24'd0) begin
                    kind_reg <= PK_ZERO;
                end else if ((x28 <<< 2) < d28) begin
                    kind_reg <= PK_DIV;
                    nsgn_reg <= x28 < 0;
                    sh2_reg  <= 1'b1;
                    m_reg    <= 25'((x28 < 0) ? -x28 : x28);
                end else if ((dmx28 <<< 1) < d28) begin
                    kind_reg <= PK_DIV;
                    nsgn_reg <= dmx28 < 0;
                    m_reg    <= 25'((dmx28 < 0) ? -dmx28 : dmx28);
                end else begin
                    kind_reg <= PK_CRUISE;
                end
            end
            OP_MUL_NUM: begin
                prod_reg <= mul_p;
            end
            OP_DIV_LOAD: begin
                dvd_reg <= sh2_reg ? {prod_reg[39:0], 2'b00} : {prod_reg[40:0], 1'b0};
                rem_reg <= '0;
            end
            OP_DIV_STEP: begin
                rem_reg <= div_ge ? 24'(rem_sh - {1'b0, dmag_reg}) : rem_sh[23:0];
                dvd_reg <= {dvd_reg[QUOT_W-2:0], div_ge};
            end
            OP_SET_ERR: begin
                err_r_reg <= sat32(50'(set44) - 50'(sr_reg));
                err_l_reg <= sat32(50'(setl44) - 50'(sl_reg));
            end
            OP_MR1: begin
                prod_reg <= mul_p;
            end
            OP_MR2: begin
                prod_reg <= mul_p;
                acc_reg  <= prod_reg;
            end
            OP_ML1: begin
                prod_reg <= mul_p;
                acc_reg  <= acc_reg + prod_reg;
            end
            OP_ML2: begin
                prod_reg <= mul_p;
                acc_reg  <= prod_reg;
                dr_reg   <= band(trunc_shr(acc_reg, 8), dirneg_reg, dmin_reg, dmax_reg);
            end
            OP_MC: begin
                prod_reg <= mul_p;
                acc_reg  <= acc_reg + prod_reg;
            end
            OP_CORR: begin
                dl_reg   <= band(trunc_shr(acc_reg, 8), dirneg_l, dmin_reg, dmax_reg);
                corr_reg <= 32'(trunc_shr(prod_reg, 12));
            end
            OP_FIN: begin
                if (arrived_reg) begin
                    out_r_reg   <= '0;
                    out_l_reg   <= '0;
                    out_arr_reg <= 1'b1;
                end else begin
                    out_r_reg   <= band(fin_r, dirneg_reg, dmin_reg, dmax_reg);
                    out_l_reg   <= band(fin_l, dirneg_l, dmin_reg, dmax_reg);
                    out_arr_reg <= 1'b0;
                end
            end
            default: begin
                acc_reg <= acc_reg;
            end
        endcase
    end

    assign status.arrived  = arrived_reg;
    assign status.need_div = (kind_reg == PK_DIV);
    assign status.div_last = (cnt_reg == 6'd0);

    assign drive_right = out_r_reg;
    assign drive_left  = out_l_reg;
    assign arrived     = out_arr_reg;

endmodule
